[rtl/core/swm_pkg.sv]
package swm_pkg;

    // Fixed field widths
    localparam int SAMPLE_W       = 16;
    localparam int CFG_W          = 9;
    localparam int SUM_W          = 48;

    // Default depth of the cell chain
    localparam int MAX_WINDOW_DEF = 256;

    // Window size after reset
    localparam logic [CFG_W-1:0] WS_RESET = CFG_W'(3);

    // Sum saturation value
    localparam logic [SUM_W-1:0] SUM_MAX  = '1;

    // Control flags of the token that walks the cell chain
    typedef struct packed {
        logic vld;    // token present at this cell boundary
        logic ins;    // new sample already placed upstream
        logic del;    // expired entry already dropped upstream
        logic found;  // median already picked upstream
    } t_tok_ctl;

endpackage

[rtl/core/swm_ifs.sv]
// Sample input channel
interface swm_in_if import swm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                start_sequence;

    modport source (output valid, output sample, output start_sequence, input ready);
    modport sink   (input valid, input sample, input start_sequence, output ready);
endinterface

// Result output channel
interface swm_out_if import swm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] median;
    logic [SUM_W-1:0]    median_sum;

    modport source (output valid, output median, output median_sum, input ready);
    modport sink   (input valid, input median, input median_sum, output ready);
endinterface

// Window size write channel
interface swm_cfg_if import swm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

[rtl/core/swm_cell.sv]
// One slot of the sorted window. The token visits each cell once per sample,
// rewrites its slot with the next element of the merged order and passes on.
module swm_cell import swm_pkg::*; #(
    parameter  int MAX_WINDOW = MAX_WINDOW_DEF,
    localparam int AW         = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int KW         = $clog2(MAX_WINDOW + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // broadcast from the top level for the current sample
    input  logic [SAMPLE_W-1:0] i_new,
    input  logic                i_clr,
    input  logic [KW-1:0]       i_k,
    input  logic [KW-1:0]       i_rank,
    // token from the left neighbor
    input  t_tok_ctl            i_tok,
    input  logic [SAMPLE_W-1:0] i_prev_v,
    input  logic [AW-1:0]       i_prev_age,
    input  logic                i_prev_vld,
    input  logic [KW-1:0]       i_cnt,
    input  logic [SAMPLE_W-1:0] i_med,
    // stored entry of the right neighbor
    input  logic [SAMPLE_W-1:0] i_nxt_v,
    input  logic [AW-1:0]       i_nxt_age,
    input  logic                i_nxt_vld,
    // own stored entry
    output logic [SAMPLE_W-1:0] o_v,
    output logic [AW-1:0]       o_age,
    output logic                o_vld,
    // token to the right neighbor
    output t_tok_ctl            o_tok,
    output logic [SAMPLE_W-1:0] o_prev_v,
    output logic [AW-1:0]       o_prev_age,
    output logic                o_prev_vld,
    output logic [KW-1:0]       o_cnt,
    output logic [SAMPLE_W-1:0] o_med
);

    localparam logic [AW-1:0] AGE_LAST = AW'(MAX_WINDOW - 1);

    logic [SAMPLE_W-1:0] r_v;
    logic [AW-1:0]       r_age;
    logic                r_vld;

    t_tok_ctl            r_tok;
    logic [SAMPLE_W-1:0] r_prev_v;
    logic [AW-1:0]       r_prev_age;
    logic                r_prev_vld;
    logic [KW-1:0]       r_cnt;
    logic [SAMPLE_W-1:0] r_med;

    logic                cur_vld;
    logic                nxt_vld;
    logic                cur_del;
    logic                del_now;
    logic [SAMPLE_W-1:0] head_v;
    logic [AW-1:0]       head_age;
    logic                head_vld;
    logic                take_new;
    logic [SAMPLE_W-1:0] n_v;
    logic [AW-1:0]       n_age;
    logic                n_vld;
    logic                in_win;
    logic [KW-1:0]       n_cnt;
    t_tok_ctl            n_tok;
    logic [SAMPLE_W-1:0] n_med;

    // A clearing sample sees every old entry as empty
    assign cur_vld = r_vld & ~i_clr;
    assign nxt_vld = i_nxt_vld & ~i_clr;
    assign cur_del = cur_vld && (r_age == AGE_LAST);
    assign del_now = ~i_tok.del & cur_del;

    // Head of the remaining old elements, given what happened upstream
    always_comb begin
        if (i_tok.ins && !i_tok.del) begin
            head_v   = i_prev_v;
            head_age = i_prev_age;
            head_vld = i_prev_vld;
        end else if (i_tok.ins || (!i_tok.del && !cur_del)) begin
            head_v   = r_v;
            head_age = r_age;
            head_vld = cur_vld;
        end else begin
            head_v   = i_nxt_v;
            head_age = i_nxt_age;
            head_vld = nxt_vld;
        end
    end

    // New sample goes in ahead of the first head that is empty or not smaller than it
    assign take_new = !i_tok.ins && (!head_vld || (i_new <= head_v));

    always_comb begin
        if (take_new) begin
            n_v   = i_new;
            n_age = '0;
            n_vld = 1'b1;
        end else begin
            n_v   = head_v;
            n_age = head_age + AW'(1);
            n_vld = head_vld;
        end
    end

    // Rank count over entries young enough to be in the window
    assign in_win = n_vld && (KW'(n_age) < i_k);
    assign n_cnt  = i_cnt + KW'(in_win);

    always_comb begin
        n_tok       = i_tok;
        n_tok.ins   = i_tok.ins | take_new;
        n_tok.del   = i_tok.del | del_now;
        n_med       = i_med;
        if (!i_tok.found && in_win && (n_cnt == i_rank)) begin
            n_tok.found = 1'b1;
            n_med       = n_v;
        end
    end

    // Slot valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_tok.vld) begin
            r_vld <= n_vld;
        end
    end

    // Slot payload
    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_v   <= n_v;
            r_age <= n_age;
        end
    end

    // Token control hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.vld <= i_tok.vld;
            if (i_tok.vld) begin
                r_tok.ins   <= n_tok.ins;
                r_tok.del   <= n_tok.del;
                r_tok.found <= n_tok.found;
            end
        end
    end

    // Token payload hand-off; the old entry moves right when pushed
    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_prev_v   <= r_v;
            r_prev_age <= r_age;
            r_prev_vld <= cur_vld;
            r_cnt      <= n_cnt;
            r_med      <= n_med;
        end
    end

    assign o_v        = r_v;
    assign o_age      = r_age;
    assign o_vld      = r_vld;
    assign o_tok      = r_tok;
    assign o_prev_v   = r_prev_v;
    assign o_prev_age = r_prev_age;
    assign o_prev_vld = r_prev_vld;
    assign o_cnt      = r_cnt;
    assign o_med      = r_med;

endmodule

[rtl/core/sliding_window_median_unit.sv]
// Channel   Dir  Modport  Payload
// i_in      in   sink     sample[15:0], start_sequence
// o_out     out  source   median[15:0], median_sum[47:0]
// i_cfg     in   sink     window_size[8:0]
//
// A sample passes a launch register, the token walk through the MAX_WINDOW sorted cells,
// the finish register and, when it yields a result, the output register. The next input
// transfer can come once the token has left the chain and, with a result, once the result
// has moved from the finish register into the output register.
// A result waiting in the output register does not block i_in; a second result
// held in the finish register behind it does, until o_out transfers.
// Synchronous active-low reset empties all cells, clears the sum and fill
// count and sets window_size to 3. i_cfg is always ready.
module sliding_window_median_unit import swm_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swm_in_if.sink      i_in,
    swm_out_if.source   o_out,
    swm_cfg_if.sink     i_cfg
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (KW > CFG_W) ? KW : CFG_W;

    logic [CFG_W-1:0]    r_ws;
    logic                r_busy;
    logic                r_start;
    logic [SAMPLE_W-1:0] r_new;
    logic                r_clr;
    logic [KW-1:0]       r_k;
    logic [KW-1:0]       r_rank;
    logic                r_emit;
    logic [KW-1:0]       r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic                r_fin_vld;
    logic [SAMPLE_W-1:0] r_fin_med;
    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_out_med;
    logic [SUM_W-1:0]    r_out_sum;

    logic                in_xfer;
    logic                drain;
    logic                tok_exit;
    logic [CW-1:0]       ws_ext;
    logic [KW-1:0]       k_eff;
    logic [KW-1:0]       n_fill;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    n_sum;

    // Chain wiring
    t_tok_ctl            tok_ctl    [MAX_WINDOW+1];
    logic [SAMPLE_W-1:0] tok_prev_v [MAX_WINDOW+1];
    logic [AW-1:0]       tok_prev_a [MAX_WINDOW+1];
    logic                tok_prev_e [MAX_WINDOW+1];
    logic [KW-1:0]       tok_cnt    [MAX_WINDOW+1];
    logic [SAMPLE_W-1:0] tok_med    [MAX_WINDOW+1];
    logic [SAMPLE_W-1:0] cell_v     [MAX_WINDOW];
    logic [AW-1:0]       cell_age   [MAX_WINDOW];
    logic                cell_vld   [MAX_WINDOW];

    // Handshakes
    assign i_in.ready  = !r_busy && !r_fin_vld;
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign tok_exit    = tok_ctl[MAX_WINDOW].vld;
    assign drain       = r_fin_vld && (!r_out_vld || o_out.ready);

    // Effective window size: zero acts as one, large values clip to the chain
    always_comb begin
        ws_ext = CW'(r_ws);
        if (ws_ext == '0) begin
            k_eff = KW'(1);
        end else if (ws_ext > CW'(MAX_WINDOW)) begin
            k_eff = KW'(MAX_WINDOW);
        end else begin
            k_eff = KW'(ws_ext);
        end
    end

    // Fill count after this sample
    always_comb begin
        if (i_in.start_sequence) begin
            n_fill = KW'(1);
        end else if (r_fill == KW'(MAX_WINDOW)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + KW'(1);
        end
    end

    // Saturating running sum
    assign sum_wide = {1'b0, r_sum} + (SUM_W+1)'(r_fin_med);
    assign n_sum    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= WS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_ws <= i_cfg.window_size;
        end
    end

    // Sequencing control: launch, busy, fill, finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_start   <= 1'b0;
            r_fill    <= '0;
            r_fin_vld <= 1'b0;
        end else begin
            r_start <= in_xfer;
            if (in_xfer) begin
                r_busy <= 1'b1;
                r_fill <= n_fill;
            end else if (tok_exit) begin
                r_busy <= 1'b0;
            end
            if (tok_exit) begin
                r_fin_vld <= r_emit;
            end else if (drain) begin
                r_fin_vld <= 1'b0;
            end
        end
    end

    // Per-sample broadcast values
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_new  <= i_in.sample;
            r_clr  <= i_in.start_sequence;
            r_k    <= k_eff;
            r_rank <= KW'(({1'b0, k_eff} + (KW+1)'(1)) >> 1);
            r_emit <= (n_fill >= k_eff);
        end
    end

    // Median captured at the chain end
    always_ff @(posedge i_clk) begin
        if (tok_exit) begin
            r_fin_med <= tok_med[MAX_WINDOW];
        end
    end

    // Running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (in_xfer && i_in.start_sequence) begin
            r_sum <= '0;
        end else if (drain) begin
            r_sum <= n_sum;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (drain) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_out_med <= r_fin_med;
            r_out_sum <= n_sum;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.median     = r_out_med;
    assign o_out.median_sum = r_out_sum;

    // Token entering cell 0
    assign tok_ctl[0]    = '{vld: r_start, ins: 1'b0, del: 1'b0, found: 1'b0};
    assign tok_prev_v[0] = '0;
    assign tok_prev_a[0] = '0;
    assign tok_prev_e[0] = 1'b0;
    assign tok_cnt[0]    = '0;
    assign tok_med[0]    = '0;

    // Chain of sorted cells
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic [SAMPLE_W-1:0] nxt_v;
        logic [AW-1:0]       nxt_age;
        logic                nxt_vld;

        if (g == MAX_WINDOW - 1) begin : g_last
            assign nxt_v   = '0;
            assign nxt_age = '0;
            assign nxt_vld = 1'b0;
        end else begin : g_mid
            assign nxt_v   = cell_v[g+1];
            assign nxt_age = cell_age[g+1];
            assign nxt_vld = cell_vld[g+1];
        end

        swm_cell #(
            .MAX_WINDOW (MAX_WINDOW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_new      (r_new),
            .i_clr      (r_clr),
            .i_k        (r_k),
            .i_rank     (r_rank),
            .i_tok      (tok_ctl[g]),
            .i_prev_v   (tok_prev_v[g]),
            .i_prev_age (tok_prev_a[g]),
            .i_prev_vld (tok_prev_e[g]),
            .i_cnt      (tok_cnt[g]),
            .i_med      (tok_med[g]),
            .i_nxt_v    (nxt_v),
            .i_nxt_age  (nxt_age),
            .i_nxt_vld  (nxt_vld),
            .o_v        (cell_v[g]),
            .o_age      (cell_age[g]),
            .o_vld      (cell_vld[g]),
            .o_tok      (tok_ctl[g+1]),
            .o_prev_v   (tok_prev_v[g+1]),
            .o_prev_age (tok_prev_a[g+1]),
            .o_prev_vld (tok_prev_e[g+1]),
            .o_cnt      (tok_cnt[g+1]),
            .o_med      (tok_med[g+1])
        );
    end

    // A token only leaves the chain for a sample in flight
    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_exit |-> r_busy)
        else $error("token left chain while idle");

    // Every token has placed its sample by the end of the chain
    a_exit_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_exit |-> tok_ctl[MAX_WINDOW].ins)
        else $error("sample not inserted");

    // A full window holds exactly k in-window entries and yields a median
    a_exit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_exit && r_emit) |-> (tok_cnt[MAX_WINDOW] == r_k) && tok_ctl[MAX_WINDOW].found)
        else $error("median rank walk inconsistent");

    // Sum only drops on a sequence restart
    a_sum_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_sum < $past(r_sum))) |->
            $past(in_xfer && i_in.start_sequence))
        else $error("running sum decreased");

endmodule
